// ===== hdl/tfh_pkg.sv =====
// Package for the TCP flow hash table: operation and status codes, entry and
// transaction payload types, controller states and the bucket hash fold.
// No dependencies.
package tfh_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int WAYS_DEF    = 4;

	// operation codes; the spare code behaves as a query
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;

	// result status codes
	localparam logic [2:0] STS_INSERTED  = 3'd0;
	localparam logic [2:0] STS_DUPLICATE = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_FOUND     = 3'd3;
	localparam logic [2:0] STS_NOT_FOUND = 3'd4;
	localparam logic [2:0] STS_DELETED   = 3'd5;

	typedef struct packed {
		logic        [1:0]  func;
		logic        [31:0] src_ip;
		logic        [31:0] dst_ip;
		logic        [15:0] src_port;
		logic        [15:0] dst_port;
		logic signed [31:0] syn_stamp;
	} in_item_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic               hit;
		logic signed [31:0] stored_time;
	} out_item_t;

	// one stored connection; port_pair holds src_port in 15:0, dst_port in 31:16
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] port_pair;
		logic [31:0] start_time;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_LOOK
	} state_t;

	function automatic logic [31:0] hash_fold(input logic [31:0] sip, input logic [31:0] dip,
			input logic [15:0] sp, input logic [15:0] dp);
		logic [31:0] h;
		h = (sip ^ {16'd0, sp}) ^ (dip ^ {16'd0, dp});
		h = h ^ (h >> 16);
		h = h ^ (h >> 8);
		return h;
	endfunction

endpackage

// ===== hdl/tfh_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; payload type given at instantiation.
interface tfh_chan_if #(parameter type payload_t = logic [0:0]);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tfh_ram.sv =====
// Single-port-write, single-port-read synchronous memory, registered read.
// No dependencies.
module tfh_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hdl/tfh_bucket_reduce.sv =====
// Reduces the folded 32-bit hash to a bucket index modulo BUCKETS.
// Uses tfh_pkg. Power-of-two counts mask combinationally; others register the reciprocal quotient, then the remainder.
module tfh_bucket_reduce #(
	parameter int BUCKETS = tfh_pkg::BUCKETS_DEF,
	parameter int AW      = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   hash,
	output logic          done,
	output logic [AW-1:0] bucket
);
	localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	if (POW2) begin : g_mask
		logic [31:0] masked;
		assign masked = hash & 32'(BUCKETS - 1);
		assign done   = start;
		assign bucket = masked[AW-1:0];
	end else begin : g_recip
		// floor(2^32 / BUCKETS); the estimate undershoots the quotient by at most one
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

		logic          v_s1, v_s2;
		logic [31:0]   h_s1, q_s1;
		logic [AW-1:0] bucket_s2;
		logic [63:0]   prod;
		logic [31:0]   qb, rem, rem_fix;

		assign prod    = 64'(hash) * 64'(RECIP);
		assign qb      = 32'(q_s1 * 32'(BUCKETS));
		assign rem     = h_s1 - qb;
		assign rem_fix = (rem >= 32'(BUCKETS)) ? rem - 32'(BUCKETS) : rem;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else begin
				v_s1 <= start;
				v_s2 <= v_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				h_s1 <= hash;
				q_s1 <= prod[63:32];
			end
			if (v_s1) begin
				bucket_s2 <= rem_fix[AW-1:0];
			end
		end

		assign done   = v_s2;
		assign bucket = bucket_s2;
	end
endmodule

// ===== hdl/tfh_way_match.sv =====
// Compares the ways of one bucket row against a connection tuple in both
// directions; returns lowest matching way and lowest free way, one-hot. Uses tfh_pkg.
module tfh_way_match #(
	parameter int WAYS = tfh_pkg::WAYS_DEF
) (
	input  logic [WAYS-1:0]            valid,
	input  tfh_pkg::entry_t [WAYS-1:0] ent,
	input  tfh_pkg::in_item_t          key,
	output logic [WAYS-1:0]            match_oh,
	output logic [WAYS-1:0]            free_oh
);
	logic [31:0]     fwd, rev;
	logic [WAYS-1:0] match_raw;

	assign fwd = {key.dst_port, key.src_port};
	assign rev = {key.src_port, key.dst_port};

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match_raw[w] = valid[w] &&
				((ent[w].src_addr == key.src_ip && ent[w].dst_addr == key.dst_ip &&
				  ent[w].port_pair == fwd) ||
				 (ent[w].src_addr == key.dst_ip && ent[w].dst_addr == key.src_ip &&
				  ent[w].port_pair == rev));
		end
	end

	// isolate the lowest set bit
	assign match_oh = match_raw & (~match_raw + WAYS'(1));
	assign free_oh  = ~valid & (valid + WAYS'(1));
endmodule

// ===== hdl/tcp_flow_hash_table.sv =====
// TCP flow hash table, top level: controller, bucket row memory, output register.
// Result registered after the bucket row read, which follows the two-stage reciprocal
// reduction when BUCKETS is not a power of two. One item at a time: a new one is
// accepted after the last row's write-back, which waits while a result is untaken.
// After reset a clearing pass zeroes the valid bits; no item is accepted until it ends.
// Uses tfh_pkg, tfh_chan_if, tfh_ram, tfh_bucket_reduce, tfh_way_match.
module tcp_flow_hash_table #(
	parameter int BUCKETS = tfh_pkg::BUCKETS_DEF,
	parameter int WAYS    = tfh_pkg::WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tfh_chan_if.sink      in_ch,
	tfh_chan_if.source    out_ch
);
	localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	// one memory row holds the whole bucket, valid bits alongside the entries
	typedef struct packed {
		logic [WAYS-1:0]            valid;
		tfh_pkg::entry_t [WAYS-1:0] ent;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	tfh_pkg::state_t   state_q, state_nxt;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     bkt_q;
	tfh_pkg::in_item_t item_q;
	tfh_pkg::out_item_t out_q, out_nxt;
	logic              out_vld_q;

	logic              in_acc, finish, slot_free;
	logic              red_done;
	logic [AW-1:0]     red_bucket;
	logic [31:0]       hash;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	row_t              wr_row, rd_row, new_row;
	logic [ROW_W-1:0]  rd_bits;

	logic [WAYS-1:0]   match_oh, free_oh;
	logic              found, have_free, is_ins, is_del, do_ins, do_del;
	logic [31:0]       hit_time;

	// ---------------------------------------------------------------
	// Bucket selection: fold the tuple straight from the input port so
	// that a power-of-two table issues its row read in the accept cycle.
	// ---------------------------------------------------------------
	assign hash = tfh_pkg::hash_fold(in_ch.payload.src_ip, in_ch.payload.dst_ip,
		in_ch.payload.src_port, in_ch.payload.dst_port);

	tfh_bucket_reduce #(.BUCKETS(BUCKETS), .AW(AW)) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.hash   (hash),
		.done   (red_done),
		.bucket (red_bucket)
	);

	// ---------------------------------------------------------------
	// Row memory
	// ---------------------------------------------------------------
	tfh_ram #(.DEPTH(BUCKETS), .WIDTH(ROW_W), .AW(AW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_row),
		.rd_en   (red_done),
		.rd_addr (red_bucket),
		.rd_data (rd_bits)
	);

	assign rd_row = row_t'(rd_bits);

	// ---------------------------------------------------------------
	// Way compare on the row just read
	// ---------------------------------------------------------------
	tfh_way_match #(.WAYS(WAYS)) u_match (
		.valid    (rd_row.valid),
		.ent      (rd_row.ent),
		.key      (item_q),
		.match_oh (match_oh),
		.free_oh  (free_oh)
	);

	assign found     = |match_oh;
	assign have_free = |free_oh;
	assign is_ins    = item_q.func == tfh_pkg::FUNC_INSERT;
	assign is_del    = item_q.func == tfh_pkg::FUNC_DELETE;
	assign do_ins    = is_ins && !found && have_free;
	assign do_del    = is_del && found;

	// stored time of the matching way, zero when none matches
	always_comb begin
		hit_time = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (match_oh[w]) begin
				hit_time = hit_time | rd_row.ent[w].start_time;
			end
		end
	end

	// modified row: drop the matching way on delete, fill the lowest free way on insert
	always_comb begin
		new_row = rd_row;
		if (do_del) begin
			new_row.valid = rd_row.valid & ~match_oh;
		end
		if (do_ins) begin
			new_row.valid = rd_row.valid | free_oh;
			for (int w = 0; w < WAYS; w++) begin
				if (free_oh[w]) begin
					new_row.ent[w].src_addr   = item_q.src_ip;
					new_row.ent[w].dst_addr   = item_q.dst_ip;
					new_row.ent[w].port_pair  = {item_q.dst_port, item_q.src_port};
					new_row.ent[w].start_time = item_q.syn_stamp;
				end
			end
		end
	end

	// result of the current lookup
	always_comb begin
		out_nxt.hit         = found;
		out_nxt.stored_time = '0;
		priority if (is_ins) begin
			if (found) begin
				out_nxt.status = tfh_pkg::STS_DUPLICATE;
			end else if (!have_free) begin
				out_nxt.status = tfh_pkg::STS_FULL;
			end else begin
				out_nxt.status = tfh_pkg::STS_INSERTED;
			end
		end else if (is_del) begin
			out_nxt.status = found ? tfh_pkg::STS_DELETED : tfh_pkg::STS_NOT_FOUND;
		end else begin
			// query, and the spare code which behaves as one
			out_nxt.status = found ? tfh_pkg::STS_FOUND : tfh_pkg::STS_NOT_FOUND;
			if (found) begin
				out_nxt.stored_time = hit_time;
			end
		end
	end

	// ---------------------------------------------------------------
	// Controller: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tfh_pkg::S_CLEAR: begin
				if (clr_q == AW'(BUCKETS - 1)) begin
					state_nxt = tfh_pkg::S_IDLE;
				end
			end
			tfh_pkg::S_IDLE: begin
				if (in_acc) begin
					state_nxt = red_done ? tfh_pkg::S_LOOK : tfh_pkg::S_HASH;
				end
			end
			tfh_pkg::S_HASH: begin
				if (red_done) begin
					state_nxt = tfh_pkg::S_LOOK;
				end
			end
			tfh_pkg::S_LOOK: begin
				if (finish) begin
					state_nxt = tfh_pkg::S_IDLE;
				end
			end
			default: state_nxt = tfh_pkg::S_CLEAR;
		endcase
	end

	// ---------------------------------------------------------------
	// Controller: outputs. A finished lookup waits in LOOK only while the
	// output register still holds an untaken transaction.
	// ---------------------------------------------------------------
	assign slot_free = !out_vld_q || out_ch.ready;

	always_comb begin
		in_ch.ready = 1'b0;
		finish      = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = bkt_q;
		wr_row      = new_row;
		unique case (state_q)
			tfh_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_row  = '0;
			end
			tfh_pkg::S_IDLE: begin
				in_ch.ready = 1'b1;
			end
			tfh_pkg::S_HASH: begin
			end
			tfh_pkg::S_LOOK: begin
				finish = slot_free;
				wr_en  = slot_free;
			end
			default: begin
			end
		endcase
	end

	assign in_acc = in_ch.valid && in_ch.ready;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tfh_pkg::S_CLEAR;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == tfh_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers: hold the item, the bucket and the result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_ch.payload;
		end
		if (red_done) begin
			bkt_q <= red_bucket;
		end
		if (finish) begin
			out_q <= out_nxt;
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.payload = out_q;
endmodule

// ===== hdl/tfh_checker.sv =====
// Port-level checker for the TCP flow hash table, bound to the top level.
// Uses tfh_pkg.
module tfh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        out_status,
	input logic              out_hit,
	input logic signed [31:0] out_time
);
	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// one item at a time: no transaction in the cycle after an acceptance
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// hit flag agrees with the status code
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_hit == (out_status == tfh_pkg::STS_DUPLICATE ||
			out_status == tfh_pkg::STS_FOUND || out_status == tfh_pkg::STS_DELETED)))
		else $error("hit flag inconsistent with status");

	// time reported only on a query hit
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != tfh_pkg::STS_FOUND) |-> out_time == 32'sd0)
		else $error("stored time non-zero outside a query hit");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_time)))
		else $error("stalled result changed");
endmodule

bind tcp_flow_hash_table tfh_checker u_tfh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.payload.status),
	.out_hit    (out_ch.payload.hit),
	.out_time   (out_ch.payload.stored_time)
);
